FILE: sv/hbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbm_pkg
// Shared widths, register indexes and types for the histogram bin merger.
// ----------------------------------------------------------------------------
package hbm_pkg;

   // field widths
   localparam int DIST_W  = 32;
   localparam int BCNT_W  = 32;
   localparam int ABS_W   = 16;
   localparam int RECIP_W = 8;
   localparam int GCNT_W  = 40;
   localparam int GIDX_W  = 16;
   localparam int TOTAL_W = 48;
   localparam int WSUM_W  = 64;

   // register port
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam logic [RECIP_W-1:0] RECIP_RESET = 8'd50;
   localparam logic REG_ABS_LIMIT = 1'b0;
   localparam logic REG_REL_RECIP = 1'b1;

   // shared arithmetic unit
   localparam int ALU_A_W   = 64;
   localparam int ALU_B_W   = 40;
   localparam int ALU_W_W   = ALU_A_W + ALU_B_W;
   localparam int ALU_CNT_W = 7;
   localparam logic [ALU_CNT_W-1:0] MUL_STEPS = 7'd40;
   localparam logic [ALU_CNT_W-1:0] DIV_STEPS = 7'd64;
   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;

   typedef struct packed {
      logic               start;
      logic               op;
      logic [ALU_A_W-1:0] a;   // multiplier (low 40 bits) or dividend
      logic [ALU_B_W-1:0] b;   // multiplicand or divisor
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

   typedef struct packed {
      logic [ABS_W-1:0]   abs_limit;
      logic [RECIP_W-1:0] rel_limit_recip;
   } csr_cfg_type;

endpackage : hbm_pkg
`default_nettype wire

FILE: sv/hbm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbm_if
// Valid/ready channels for bins in and merged groups out.
// ----------------------------------------------------------------------------
interface hbm_req_if import hbm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;
   logic [BCNT_W-1:0] bin_count;
   logic              last_bin;

   modport source (output valid, distance, bin_count, last_bin, input ready);
   modport sink   (input valid, distance, bin_count, last_bin, output ready);
endinterface : hbm_req_if

interface hbm_rsp_if import hbm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DIST_W-1:0]  mean_distance;
   logic [GCNT_W-1:0]  group_count;
   logic [GIDX_W-1:0]  group_index;
   logic [TOTAL_W-1:0] running_total;
   logic               run_last;

   modport source (output valid, mean_distance, group_count, group_index,
                   running_total, run_last, input ready);
   modport sink   (input valid, mean_distance, group_count, group_index,
                   running_total, run_last, output ready);
endinterface : hbm_rsp_if
`default_nettype wire

FILE: sv/histogram_bin_merger.sv
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_bin_merger
// Merges neighbouring histogram bins into groups and emits one beat per
// closed group: rounded mean distance, count, index and running total.
// ----------------------------------------------------------------------------
//  channel  dir  handshake         payload
//  req      in   valid/ready       distance, bin_count, last_bin
//  rsp      out  valid/ready       mean_distance, group_count, group_index,
//                                  running_total, run_last
//  csr      in   APB, pready tied  abs_limit @0x0, rel_limit_recip @0x4
//
//  A bin is quickest as a zero-count bin with nothing open and slowest when it
//  closes a group, opens a new one and flushes; without output stalls this is set
//  by the shared bit-serial unit: a multiply (relative test, bin weight) runs
//  40 steps and a divide (group mean) 64.
//  A merging bin runs the relative-test multiply only if the absolute test fails.
//  req.ready is high only between bins. The rsp register holds one beat; the
//  sequencer stalls only when a second beat is due before the first is taken.
//  Synchronous active-high reset; no clearing pass.
// ----------------------------------------------------------------------------
module histogram_bin_merger import hbm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   hbm_req_if.sink            req,
   hbm_rsp_if.source          rsp,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PADDR_W-1:0] csr_paddr,
   input  logic [PDATA_W-1:0] csr_pwdata,
   output logic [PDATA_W-1:0] csr_prdata,
   output logic               csr_pready
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_TEST  = 4'd1;
   localparam logic [3:0] S_MULW  = 4'd2;
   localparam logic [3:0] S_JOIN  = 4'd3;
   localparam logic [3:0] S_PRODW = 4'd4;
   localparam logic [3:0] S_CLOSE = 4'd5;
   localparam logic [3:0] S_DIVW  = 4'd6;
   localparam logic [3:0] S_EMIT  = 4'd7;
   localparam logic [3:0] S_START = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_END   = 4'd10;

   csr_cfg_type        cfg;
   alu_cmd_type        alu_cmd;
   alu_stat_type       alu_stat;
   logic [ALU_W_W-1:0] alu_res;

   logic [3:0]         state_ff,  state_in;
   logic [DIST_W-1:0]  d_ff,      d_in;
   logic [BCNT_W-1:0]  c_ff,      c_in;
   logic               last_ff,   last_in;
   logic [DIST_W-1:0]  diff_ff,   diff_in;
   logic               flush_ff,  flush_in;
   logic [DIST_W-1:0]  first_ff,  first_in;
   logic [WSUM_W-1:0]  ws_ff,     ws_in;
   logic [GCNT_W-1:0]  oc_ff,     oc_in;
   logic [GIDX_W-1:0]  ge_ff,     ge_in;
   logic [TOTAL_W-1:0] gt_ff,     gt_in;
   logic               open_ff,   open_in;
   logic [DIST_W-1:0]  mean_ff,   mean_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]  rsp_mean_ff,  rsp_mean_in;
   logic [GCNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [GIDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic               rsp_last_ff,  rsp_last_in;

   logic               accept;
   logic               slot_free;
   logic [ALU_B_W-1:0] rel_a;
   logic [WSUM_W:0]    ws_sum;
   logic [GCNT_W:0]    oc_sum;
   logic [TOTAL_W:0]   gt_sum;
   logic [TOTAL_W-1:0] gt_new;
   logic [GCNT_W-1:0]  div_rem;
   logic               round_up;
   logic [WSUM_W:0]    q_rnd;

   hbm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   hbm_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .stat  (alu_stat),
      .res   (alu_res)
   );

   assign csr_pready = 1'b1;
   assign req.ready  = (state_ff == S_IDLE);
   assign accept     = req.valid & req.ready;
   assign slot_free  = ~rsp_valid_ff | rsp.ready;

   // datapath helpers
   always_comb begin
      rel_a    = {{(ALU_B_W-RECIP_W){1'b0}}, cfg.rel_limit_recip}
                 * {{(ALU_B_W-DIST_W){1'b0}}, diff_ff};
      ws_sum   = {1'b0, ws_ff} + {1'b0, alu_res[WSUM_W-1:0]};
      oc_sum   = {1'b0, oc_ff} + {{(GCNT_W-BCNT_W+1){1'b0}}, c_ff};
      gt_sum   = {1'b0, gt_ff} + {{(TOTAL_W-GCNT_W+1){1'b0}}, oc_ff};
      gt_new   = gt_sum[TOTAL_W] ? '1 : gt_sum[TOTAL_W-1:0];
      div_rem  = alu_res[ALU_W_W-1:ALU_A_W];
      round_up = {div_rem, 1'b0} >= {1'b0, oc_ff};
      q_rnd    = {1'b0, alu_res[WSUM_W-1:0]} + {{WSUM_W{1'b0}}, round_up};
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      d_in         = d_ff;
      c_in         = c_ff;
      last_in      = last_ff;
      diff_in      = diff_ff;
      flush_in     = flush_ff;
      first_in     = first_ff;
      ws_in        = ws_ff;
      oc_in        = oc_ff;
      ge_in        = ge_ff;
      gt_in        = gt_ff;
      open_in      = open_ff;
      mean_in      = mean_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_count_in = rsp_count_ff;
      rsp_index_in = rsp_index_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;
      alu_cmd      = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               d_in     = req.distance;
               c_in     = req.bin_count;
               last_in  = req.last_bin;
               diff_in  = (req.distance > first_ff) ? req.distance - first_ff : '0;
               state_in = S_TEST;
            end
         end
         // absolute test, then relative test as recip*diff*count <= sum
         S_TEST: begin
            flush_in = 1'b0;
            if (!open_ff) begin
               state_in = S_START;
            end else if (diff_ff <= {{(DIST_W-ABS_W){1'b0}}, cfg.abs_limit}) begin
               state_in = S_JOIN;
            end else if (ws_ff == '0) begin
               state_in = S_CLOSE;
            end else if (cfg.rel_limit_recip == '0) begin
               state_in = S_JOIN;
            end else begin
               alu_cmd.start = 1'b1;
               alu_cmd.op    = OP_MUL;
               alu_cmd.a     = {{(ALU_A_W-GCNT_W){1'b0}}, oc_ff};
               alu_cmd.b     = rel_a;
               state_in      = S_MULW;
            end
         end
         S_MULW: begin
            if (alu_stat.done) begin
               if (alu_res[2*ALU_B_W-1:0] <= {{(2*ALU_B_W-WSUM_W){1'b0}}, ws_ff})
                  state_in = S_JOIN;
               else
                  state_in = S_CLOSE;
            end
         end
         // bin weight distance*count
         S_JOIN: begin
            alu_cmd.start = 1'b1;
            alu_cmd.op    = OP_MUL;
            alu_cmd.a     = {{(ALU_A_W-DIST_W){1'b0}}, d_ff};
            alu_cmd.b     = {{(ALU_B_W-BCNT_W){1'b0}}, c_ff};
            state_in      = S_PRODW;
         end
         S_PRODW: begin
            if (alu_stat.done) begin
               ws_in    = ws_sum[WSUM_W] ? '1 : ws_sum[WSUM_W-1:0];
               oc_in    = oc_sum[GCNT_W] ? '1 : oc_sum[GCNT_W-1:0];
               state_in = S_FIN;
            end
         end
         // group mean
         S_CLOSE: begin
            alu_cmd.start = 1'b1;
            alu_cmd.op    = OP_DIV;
            alu_cmd.a     = ws_ff;
            alu_cmd.b     = oc_ff;
            state_in      = S_DIVW;
         end
         S_DIVW: begin
            if (alu_stat.done) begin
               mean_in  = (q_rnd[WSUM_W:DIST_W] != '0) ? '1 : q_rnd[DIST_W-1:0];
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               rsp_count_in = oc_ff;
               rsp_index_in = ge_ff;
               rsp_total_in = gt_new;
               rsp_last_in  = flush_ff | (last_ff & (c_ff == '0));
               gt_in        = gt_new;
               ge_in        = ge_ff + 1'b1;
               open_in      = 1'b0;
               ws_in        = '0;
               oc_in        = '0;
               first_in     = '0;
               state_in     = flush_ff ? S_END : S_START;
            end
         end
         // zero-count bin never opens a group
         S_START: begin
            if (c_ff != '0) begin
               open_in  = 1'b1;
               first_in = d_ff;
               state_in = S_JOIN;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (open_ff) begin
               flush_in = 1'b1;
               state_in = S_CLOSE;
            end else begin
               state_in = S_END;
            end
         end
         // end of histogram
         S_END: begin
            ge_in    = '0;
            gt_in    = '0;
            open_in  = 1'b0;
            ws_in    = '0;
            oc_in    = '0;
            first_in = '0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= '0;
         ws_ff        <= '0;
         oc_ff        <= '0;
         ge_ff        <= '0;
         gt_ff        <= '0;
         open_ff      <= 1'b0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         ws_ff        <= ws_in;
         oc_ff        <= oc_in;
         ge_ff        <= ge_in;
         gt_ff        <= gt_in;
         open_ff      <= open_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      d_ff         <= d_in;
      c_ff         <= c_in;
      last_ff      <= last_in;
      diff_ff      <= diff_in;
      mean_ff      <= mean_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_count_ff <= rsp_count_in;
      rsp_index_ff <= rsp_index_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.mean_distance = rsp_mean_ff;
   assign rsp.group_count   = rsp_count_ff;
   assign rsp.group_index   = rsp_index_ff;
   assign rsp.running_total = rsp_total_ff;
   assign rsp.run_last      = rsp_last_ff;

`ifndef ASSERT_OFF
   // between bins an open group always holds a nonzero count
   a_open_count: assert property (@(posedge clock) disable iff (reset)
      (open_ff && state_ff == S_IDLE) |-> (oc_ff != '0))
      else $error("open group with zero count");

   // no group open means empty accumulators
   a_closed_empty: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> (ws_ff == '0 && oc_ff == '0))
      else $error("accumulators not cleared");

   // the shared unit only runs while the sequencer waits on it
   a_alu_wait: assert property (@(posedge clock) disable iff (reset)
      alu_stat.busy |-> (state_ff == S_MULW || state_ff == S_PRODW
                         || state_ff == S_DIVW))
      else $error("arithmetic unit busy outside a wait state");

   // a pending beat blocks the next emit
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_valid_ff && !rsp.ready) |=> state_ff == S_EMIT)
      else $error("beat overwritten before it was taken");
`endif

endmodule : histogram_bin_merger
`default_nettype wire

FILE: sv/hbm_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbm_csr
// APB register file: absolute merge limit and relative tolerance reciprocal.
// ----------------------------------------------------------------------------
module hbm_csr import hbm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output csr_cfg_type        cfg
);

   logic [ABS_W-1:0]   abs_ff;
   logic [ABS_W-1:0]   abs_in;
   logic [RECIP_W-1:0] recip_ff;
   logic [RECIP_W-1:0] recip_in;
   logic               wr_en;

   assign wr_en = psel & penable & pwrite;

   // write decode on the word index
   always_comb begin
      abs_in   = abs_ff;
      recip_in = recip_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_ABS_LIMIT: abs_in   = pwdata[ABS_W-1:0];
            REG_REL_RECIP: recip_in = pwdata[RECIP_W-1:0];
            default:       abs_in   = abs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_ff   <= '0;
         recip_ff <= RECIP_RESET;
      end else begin
         abs_ff   <= abs_in;
         recip_ff <= recip_in;
      end
   end

   // read-back
   always_comb begin
      case (paddr[2])
         REG_ABS_LIMIT: prdata = {{(PDATA_W-ABS_W){1'b0}}, abs_ff};
         REG_REL_RECIP: prdata = {{(PDATA_W-RECIP_W){1'b0}}, recip_ff};
         default:       prdata = '0;
      endcase
   end

   assign cfg.abs_limit       = abs_ff;
   assign cfg.rel_limit_recip = recip_ff;

endmodule : hbm_csr
`default_nettype wire

FILE: sv/hbm_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbm_alu
// Shared bit-serial unit: shift-add multiply (40 steps) or restoring divide
// (64 steps), both on one 41 bit adder/subtractor.
// ----------------------------------------------------------------------------
module hbm_alu import hbm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  alu_cmd_type        cmd,
   output alu_stat_type       stat,
   output logic [ALU_W_W-1:0] res
);

   // work register: multiply uses [79:0] as {partial, multiplier},
   // divide uses {remainder[103:64], quotient/dividend[63:0]}
   logic [ALU_W_W-1:0]   w_ff;
   logic [ALU_W_W-1:0]   w_in;
   logic [ALU_B_W-1:0]   b_ff;
   logic [ALU_B_W-1:0]   b_in;
   logic                 op_ff;
   logic                 op_in;
   logic [ALU_CNT_W-1:0] cnt_ff;
   logic [ALU_CNT_W-1:0] cnt_in;
   logic                 busy_ff;
   logic                 busy_in;
   logic                 done_ff;
   logic                 done_in;

   logic [ALU_B_W:0]     opa;
   logic [ALU_B_W:0]     opb;
   logic                 sub;
   logic [ALU_B_W+1:0]   sum;
   logic                 ge;
   logic [ALU_B_W-1:0]   rem_n;

   // the shared adder
   always_comb begin
      if (op_ff == OP_DIV) begin
         opa = w_ff[ALU_W_W-1:ALU_A_W-1];
         opb = {1'b0, b_ff};
         sub = 1'b1;
      end else begin
         opa = {1'b0, w_ff[2*ALU_B_W-1:ALU_B_W]};
         opb = w_ff[0] ? {1'b0, b_ff} : '0;
         sub = 1'b0;
      end
      sum = {1'b0, opa} + {1'b0, opb ^ {(ALU_B_W+1){sub}}}
            + {{(ALU_B_W+1){1'b0}}, sub};
      ge    = sum[ALU_B_W+1];
      rem_n = ge ? sum[ALU_B_W-1:0] : w_ff[ALU_W_W-2:ALU_A_W-1];
   end

   // sequencing of steps
   always_comb begin
      w_in    = w_ff;
      b_in    = b_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         op_in   = cmd.op;
         b_in    = cmd.b;
         busy_in = 1'b1;
         if (cmd.op == OP_DIV) begin
            w_in   = {{ALU_B_W{1'b0}}, cmd.a};
            cnt_in = DIV_STEPS;
         end else begin
            w_in   = {{ALU_A_W{1'b0}}, cmd.a[ALU_B_W-1:0]};
            cnt_in = MUL_STEPS;
         end
      end else if (busy_ff) begin
         if (op_ff == OP_DIV) begin
            w_in = {rem_n, w_ff[ALU_A_W-2:0], ge};
         end else begin
            w_in = {{(ALU_W_W-2*ALU_B_W){1'b0}}, sum[ALU_B_W:0],
                    w_ff[ALU_B_W-1:1]};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == {{(ALU_CNT_W-1){1'b0}}, 1'b1}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      w_ff  <= w_in;
      b_ff  <= b_in;
      op_ff <= op_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign res       = w_ff;

endmodule : hbm_alu
`default_nettype wire

FILE: test/histogram_bin_merger_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_bin_merger_tb
// Self-checking bench for the bin merger. Bins go in over the req channel
// and merged groups come back over rsp; both sides idle and stall at random.
// A short table of directed bins runs first. Random histograms follow under
// a range of merge limits, among them a long run that saturates the counts.
// Every group beat is checked field by field against a local predictor or a fixed row.
// ----------------------------------------------------------------------------
module histogram_bin_merger_tb;
   import hbm_pkg::*;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 250;   // longer than the longest bin without output stalls
   localparam int PHASES        = 8;
   localparam int SAT_PHASE     = 4;
   localparam int SAT_BINS      = 300;   // enough max-count bins to pin the count
   localparam int PHASE_BINS    = 50;

   // one merged group as seen on rsp
   typedef struct packed {
      logic [DIST_W-1:0]  mean_distance;
      logic [GCNT_W-1:0]  group_count;
      logic [GIDX_W-1:0]  group_index;
      logic [TOTAL_W-1:0] running_total;
      logic               run_last;
   } group_beat_type;

   // how a directed row gets its expectation
   typedef enum logic [1:0] {PREDICT, EXPECT_NONE, EXPECT_ONE} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [DIST_W-1:0] distance;
      logic [BCNT_W-1:0] bin_count;
      logic              last_bin;
      group_beat_type    fixed;
   } table_row_type;

   localparam int DIRECTED_ROWS = 21;
   localparam table_row_type DIRECTED [DIRECTED_ROWS] = '{
      // single bin histograms: result readable straight off the inputs
      '{EXPECT_ONE,  32'd100, 32'd3, 1'b1, '{32'd100, 40'd3, 16'd0, 48'd3, 1'b1}},
      '{EXPECT_NONE, 32'd500, 32'd0, 1'b1, '0},    // zero count, nothing open
      '{EXPECT_NONE, 32'd7,   32'd0, 1'b0, '0},    // zero-count starter dropped
      '{EXPECT_ONE,  32'hffffffff, 32'hffffffff, 1'b1,
        '{32'hffffffff, 40'h00ffffffff, 16'd0, 48'h0000ffffffff, 1'b1}},
      '{EXPECT_ONE,  32'd0, 32'd5, 1'b1, '{32'd0, 40'd5, 16'd0, 48'd5, 1'b1}},
      // equal and lower distances join, zero count joins, then a close
      '{PREDICT, 32'd1000, 32'd10, 1'b0, '0},
      '{PREDICT, 32'd1000, 32'd4,  1'b0, '0},
      '{PREDICT, 32'd990,  32'd6,  1'b0, '0},
      '{PREDICT, 32'd1010, 32'd0,  1'b0, '0},
      '{PREDICT, 32'd1020, 32'd5,  1'b0, '0},
      '{PREDICT, 32'd1021, 32'd1,  1'b0, '0},
      '{PREDICT, 32'd5000, 32'd2,  1'b1, '0},      // close and flush together
      // group at distance zero: weighted sum stays zero
      '{PREDICT, 32'd0, 32'd9, 1'b0, '0},
      '{PREDICT, 32'd1, 32'd3, 1'b0, '0},
      '{PREDICT, 32'd2, 32'd0, 1'b1, '0},          // close, nothing to flush
      // weighted sum saturation
      '{PREDICT, 32'hffffffff, 32'hffffffff, 1'b0, '0},
      '{PREDICT, 32'hffffffff, 32'hffffffff, 1'b0, '0},
      '{PREDICT, 32'hffffffff, 32'hffffffff, 1'b1, '0},
      // out of order distances
      '{PREDICT, 32'd80000, 32'd1, 1'b0, '0},
      '{PREDICT, 32'd3,     32'd2, 1'b1, '0},
      '{PREDICT, 32'd0,     32'd1, 1'b1, '0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [PADDR_W-1:0] csr_paddr = '0;
   logic [PDATA_W-1:0] csr_pwdata = '0;
   logic [PDATA_W-1:0] csr_prdata;
   logic               csr_pready;
   logic               rsp_accept = 1'b0;
   int                 stall_left = 0;
   int                 rsp_gap;
   int                 cycle_count = 0;
   int                 failures = 0;
   bit                 no_idle = 1'b0;

   hbm_req_if req_bus ();
   hbm_rsp_if rsp_bus ();

   assign rsp_bus.ready = rsp_accept;

   histogram_bin_merger dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // predictor state: merge limits and the open group
   // ------------------------------------------------------------------------
   logic [ABS_W-1:0]   abs_lim = '0;
   logic [RECIP_W-1:0] recip = RECIP_RESET;
   logic [DIST_W-1:0]  first_dist = '0;
   logic [WSUM_W-1:0]  wsum = '0;
   logic [GCNT_W-1:0]  open_cnt = '0;
   logic [GIDX_W-1:0]  grp_num = '0;
   logic [TOTAL_W-1:0] total = '0;
   logic               grp_open = 1'b0;

   group_beat_type closed_groups [$];    // groups closed by the current bin
   group_beat_type pending_groups [$];   // groups still owed by the block
   group_beat_type head;

   // diff / mean <= 1 / recip, done in integers
   function automatic bit within_rel(input logic [DIST_W-1:0] diff);
      logic [63:0] scaled;
      if (wsum == '0 || open_cnt == '0) return 1'b0;
      scaled = 64'(recip) * 64'(diff);
      if (scaled == '0) return 1'b1;
      return 64'(open_cnt) <= wsum / scaled;
   endfunction

   function automatic void accumulate(input logic [DIST_W-1:0] d,
                                      input logic [BCNT_W-1:0] c);
      logic [63:0] prod;
      logic [64:0] sum;
      logic [40:0] cnt;
      prod = 64'(d) * 64'(c);
      sum = {1'b0, wsum} + {1'b0, prod};
      wsum = sum[64] ? '1 : sum[63:0];
      cnt = {1'b0, open_cnt} + 41'(c);
      open_cnt = cnt[40] ? '1 : cnt[39:0];
   endfunction

   function automatic void close_group();
      group_beat_type g;
      logic [63:0] q;
      logic [63:0] rem;
      logic [48:0] tot;
      g = '0;
      if (open_cnt != '0) begin
         q = wsum / 64'(open_cnt);
         rem = wsum % 64'(open_cnt);
         if ((rem << 1) >= 64'(open_cnt)) q = q + 1;
         g.mean_distance = (q > 64'hffffffff) ? '1 : q[31:0];
      end
      tot = {1'b0, total} + 49'(open_cnt);
      total = tot[48] ? '1 : tot[47:0];
      g.group_count = open_cnt;
      g.group_index = grp_num;
      g.running_total = total;
      closed_groups = {closed_groups, g};
      grp_num = grp_num + 1'b1;
      grp_open = 1'b0;
      wsum = '0;
      open_cnt = '0;
      first_dist = '0;
   endfunction

   // one accepted bin: fills closed_groups with 0, 1 or 2 beats
   function automatic void merge_bin(input logic [DIST_W-1:0] d,
                                     input logic [BCNT_W-1:0] c,
                                     input logic lst);
      logic [DIST_W-1:0] diff;
      closed_groups.delete();
      if (grp_open) begin
         diff = (d > first_dist) ? d - first_dist : '0;
         if (diff <= 32'(abs_lim) || within_rel(diff)) accumulate(d, c);
         else close_group();
      end
      if (!grp_open && c != '0) begin
         grp_open = 1'b1;
         first_dist = d;
         wsum = '0;
         open_cnt = '0;
         accumulate(d, c);
      end
      if (lst) begin
         if (grp_open) close_group();
         if (closed_groups.size() > 0)
            closed_groups[closed_groups.size() - 1].run_last = 1'b1;
         grp_num = '0;
         total = '0;
         grp_open = 1'b0;
         wsum = '0;
         open_cnt = '0;
         first_dist = '0;
      end
   endfunction

   // mostly back to back, now and then a short gap, rarely a long one
   function automatic int idle_len();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(8, 60);
   endfunction

   function automatic logic [BCNT_W-1:0] bin_weight();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 14) return '1;
      if (r < 24) return $urandom;
      return $urandom_range(1, 2000);
   endfunction

   // ------------------------------------------------------------------------
   // req side
   // ------------------------------------------------------------------------
   task automatic send_bin(input logic [DIST_W-1:0] d, input logic [BCNT_W-1:0] c,
                           input logic lst, input row_kind_type kind,
                           input group_beat_type fixed);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.distance <= d;
      req_bus.bin_count <= c;
      req_bus.last_bin <= lst;
      do @(posedge clock); while (!req_bus.ready);
      merge_bin(d, c, lst);
      case (kind)
         PREDICT: begin
            foreach (closed_groups[i]) pending_groups = {pending_groups, closed_groups[i]};
         end
         EXPECT_ONE: begin
            pending_groups = {pending_groups, fixed};
         end
         EXPECT_NONE: ;
         default: ;
      endcase
   endtask

   // stop sending, wait for every owed beat, then let the block go quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_groups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup then access, then psel drops so back-to-back writes never overlap
   task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_ABS_LIMIT) abs_lim = value[ABS_W-1:0];
      else recip = value[RECIP_W-1:0];
      @(posedge clock);
   endtask

   // mostly ascending histograms, some cut short, some pure noise
   task automatic run_histograms(input int n_bins);
      int                sent;
      int                len;
      int                shape;
      int                step_max;
      logic [DIST_W-1:0] bin_dist;
      logic              lst;
      sent = 0;
      while (sent < n_bins) begin
         len = $urandom_range(1, 20);
         shape = $urandom_range(0, 99);
         case ($urandom_range(0, 3))
            0: step_max = 3;
            1: step_max = 300;
            2: step_max = 80000;
            default: step_max = 32'h0fffffff;
         endcase
         bin_dist = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
         for (int i = 0; i < len; i++) begin
            if (shape >= 90) bin_dist = $urandom;
            if (shape < 75) lst = (i == len - 1);
            else lst = (shape >= 90) && ($urandom_range(0, 7) == 0);
            send_bin(bin_dist, bin_weight(), lst, PREDICT, '0);
            bin_dist = bin_dist + $urandom_range(0, step_max);
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // rsp side: random stalls, then check each beat
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_accept <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_gap = idle_len();
         rsp_accept <= (rsp_gap == 0);
         stall_left <= (rsp_gap == 0) ? 0 : rsp_gap - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_groups.size() == 0) begin
            $error("group beat with none owed: mean_distance %0d, group_index %0d",
                   rsp_bus.mean_distance, rsp_bus.group_index);
            failures++;
         end else begin
            head = pending_groups.pop_front();
            if (rsp_bus.mean_distance !== head.mean_distance) begin
               $error("mean_distance: expected %0d, got %0d",
                      head.mean_distance, rsp_bus.mean_distance);
               failures++;
            end
            if (rsp_bus.group_count !== head.group_count) begin
               $error("group_count: expected %0d, got %0d",
                      head.group_count, rsp_bus.group_count);
               failures++;
            end
            if (rsp_bus.group_index !== head.group_index) begin
               $error("group_index: expected %0d, got %0d",
                      head.group_index, rsp_bus.group_index);
               failures++;
            end
            if (rsp_bus.running_total !== head.running_total) begin
               $error("running_total: expected %0d, got %0d",
                      head.running_total, rsp_bus.running_total);
               failures++;
            end
            if (rsp_bus.run_last !== head.run_last) begin
               $error("run_last: expected %0d, got %0d",
                      head.run_last, rsp_bus.run_last);
               failures++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // sequence: reset, directed table, then random phases
   // ------------------------------------------------------------------------
   initial begin
      logic [ABS_W-1:0]   abs_val;
      logic [RECIP_W-1:0] recip_val;
      logic [DIST_W-1:0]  sat_dist;
      req_bus.valid = 1'b0;
      req_bus.distance = '0;
      req_bus.bin_count = '0;
      req_bus.last_bin = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed rows under the reset limits
      foreach (DIRECTED[i])
         send_bin(DIRECTED[i].distance, DIRECTED[i].bin_count, DIRECTED[i].last_bin,
                  DIRECTED[i].kind, DIRECTED[i].fixed);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               abs_val = '0;
               recip_val = 8'd1;
            end
            1: begin
               abs_val = '1;
               recip_val = '1;
            end
            2: begin
               abs_val = '0;
               recip_val = '0;      // relative test passes on any nonzero sum
            end
            SAT_PHASE: begin
               abs_val = '1;
               recip_val = $urandom_range(0, 255);
            end
            default: begin
               abs_val = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 50);
               recip_val = $urandom_range(0, 255);
            end
         endcase
         // registers change only with the block drained
         settle();
         write_reg(REG_ABS_LIMIT, {16'($urandom), abs_val});
         write_reg(REG_REL_RECIP, {24'($urandom), recip_val});
         no_idle = (p % 3 == 2);
         if (p == SAT_PHASE) begin
            // one long group of near-max counts drives the count to saturation
            sat_dist = $urandom;
            for (int i = 0; i < SAT_BINS; i++)
               send_bin(sat_dist, ($urandom_range(0, 9) == 0) ? $urandom : '1,
                        i == SAT_BINS - 1, PREDICT, '0);
         end else begin
            run_histograms(PHASE_BINS);
         end
      end

      settle();
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule : histogram_bin_merger_tb
